/* hw/rtl/kea_pkg.sv */
// Shared types, register indexes and constants of the keyboard autorepeat block.
package kea_pkg;

  // Widths of the configuration port's index and data.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_CODES       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTERVAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EMULATE_BUTTONS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON2_KEY     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON3_KEY     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_ATTACHED  = 3'd6;

  // Input operation codes.
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Result kinds.
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_MOUSE = 1'b1;

  // Only packets of this length, with register bits of zero, cause results.
  localparam logic [3:0] PKT_LEN = 4'd5;

  // Most results per input item, and the widths that follow from it.
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Default number of result bundles held between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic       operation;
    logic [3:0] packet_length;
    logic [1:0] register_bits;
    logic [7:0] first_key_byte;
    logic [7:0] second_key_byte;
  } in_item_t;

  typedef struct packed {
    logic       event_kind;
    logic [6:0] key_code;
    logic       key_pressed;
    logic       button2_released;
    logic       button3_released;
    logic       led_sync;
    logic       last_result;
  } out_item_t;

  // All results caused by one input item, oldest in entry 0.
  typedef struct packed {
    logic [RES_CNT_W-1:0]             count;
    out_item_t [MAX_RESULTS-1:0]      res;
  } bundle_t;

  // Handshake between the bundle queue and the result side.
  typedef struct packed {
    logic valid;
    logic pop;
  } head_ctl_t;

endpackage

/* hw/rtl/kea_front.sv */
// Front part: configuration registers, repeat and button state, key translation.
module kea_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [kea_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kea_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  kea_pkg::in_item_t               in_item,
  output logic                            bundle_push,
  output kea_pkg::bundle_t                bundle
);

  localparam logic [6:0] KEY_RSHIFT   = 7'h7b;
  localparam logic [6:0] KEY_LSHIFT   = 7'h38;
  localparam logic [6:0] KEY_ROPTION  = 7'h7c;
  localparam logic [6:0] KEY_LOPTION  = 7'h3a;
  localparam logic [6:0] KEY_RCONTROL = 7'h7d;
  localparam logic [6:0] KEY_LCONTROL = 7'h36;
  localparam logic [6:0] KEY_A        = 7'h5a;
  localparam logic [6:0] KEY_CAPS     = 7'h39;
  localparam logic [6:0] KEY_NUMLOCK  = 7'h47;
  localparam logic [6:0] KEY_NOREP_LO = 7'h35;
  localparam logic [6:0] KEY_NOREP_HI = 7'h3a;
  localparam logic [6:0] KEY_NOREP_X  = 7'h6b;
  localparam logic [7:0] BYTE_ABSENT  = 8'hff;
  localparam logic [7:0] BYTE_IDLE    = 8'h7f;

  typedef struct packed {
    logic        raw_codes;
    logic [15:0] repeat_delay;
    logic [15:0] repeat_interval;
    logic        emulate_buttons;
    logic [6:0]  button2_key;
    logic [6:0]  button3_key;
    logic        mouse_attached;
  } cfg_t;

  typedef struct packed {
    logic        repeat_armed;
    logic [15:0] repeat_countdown;
    logic [6:0]  repeat_key;
    logic        button2_up;
    logic        button3_up;
  } rep_state_t;

  // Outcome of one key byte: new state and up to two results.
  typedef struct packed {
    rep_state_t                 st;
    logic [1:0]                 n;
    kea_pkg::out_item_t [1:0]   res;
  } key_res_t;

  cfg_t       cfg;
  rep_state_t st;
  rep_state_t st_next;
  rep_state_t tick_st;
  key_res_t   ka;
  key_res_t   kb;
  key_res_t   kt;
  logic       second_present;
  logic       packet_ok;

  function automatic logic no_repeat(logic [6:0] code);
    return (code >= KEY_NOREP_LO && code <= KEY_NOREP_HI) || code == KEY_NUMLOCK ||
           code == KEY_NOREP_X;
  endfunction

  function automatic kea_pkg::out_item_t key_item(logic [6:0] code, logic pressed, logic led);
    kea_pkg::out_item_t r;
    r = '0;
    r.event_kind  = kea_pkg::KIND_KEY;
    r.key_code    = code;
    r.key_pressed = pressed;
    r.led_sync    = led;
    return r;
  endfunction

  function automatic kea_pkg::out_item_t mouse_item(logic b2, logic b3);
    kea_pkg::out_item_t r;
    r = '0;
    r.event_kind       = kea_pkg::KIND_MOUSE;
    r.button2_released = b2;
    r.button3_released = b3;
    return r;
  endfunction

  // Handling of one key byte; rep marks a reissue by the repeat timer.
  function automatic key_res_t key_step(cfg_t c, rep_state_t s, logic [7:0] kbyte, logic rep);
    key_res_t   r;
    logic       up;
    logic [6:0] code;
    logic       led;
    logic       is_btn;
    r      = '0;
    r.st   = s;
    up     = kbyte[7];
    code   = kbyte[6:0];
    led    = 1'b0;
    is_btn = c.emulate_buttons && c.mouse_attached &&
             (code == c.button2_key || code == c.button3_key);
    if (!rep) begin
      r.st.repeat_armed = 1'b0;
    end
    if (is_btn) begin
      // Button keys report only a change of button state; button 2 wins a tie.
      if (code == c.button2_key) begin
        if (s.button2_up != up) begin
          r.st.button2_up = up;
          r.n             = 2'd1;
          r.res[0]        = mouse_item(up, s.button3_up);
        end
      end else if (s.button3_up != up) begin
        r.st.button3_up = up;
        r.n             = 2'd1;
        r.res[0]        = mouse_item(s.button2_up, up);
      end
    end else begin
      // Right-hand modifiers fold onto the left ones.
      case (code)
        KEY_RSHIFT:   code = KEY_LSHIFT;
        KEY_ROPTION:  code = KEY_LOPTION;
        KEY_RCONTROL: code = KEY_LCONTROL;
        default: begin
          if (code == 7'd0 && !c.raw_codes) begin
            code = KEY_A;
          end
        end
      endcase
      if (!c.raw_codes) begin
        if (!up && !no_repeat(code)) begin
          r.st.repeat_armed     = 1'b1;
          r.st.repeat_key       = code;
          r.st.repeat_countdown = rep ? c.repeat_interval : c.repeat_delay;
        end
        // Caps lock is sent as a press and then a release.
        if (code == KEY_CAPS) begin
          led      = 1'b1;
          r.res[0] = key_item(code, 1'b1, 1'b1);
          r.n      = 2'd1;
          up       = 1'b1;
        end else if (code == KEY_NUMLOCK) begin
          led = 1'b1;
        end
      end
      r.res[r.n[0]] = key_item(code, !up, led);
      r.n           = r.n + 2'd1;
    end
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_codes       <= 1'b0;
      cfg.repeat_delay    <= 16'd50;
      cfg.repeat_interval <= 16'd6;
      cfg.emulate_buttons <= 1'b1;
      cfg.button2_key     <= 7'd124;
      cfg.button3_key     <= 7'd125;
      cfg.mouse_attached  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kea_pkg::REG_RAW_CODES:       cfg.raw_codes       <= cfg_data[0];
        kea_pkg::REG_REPEAT_DELAY:    cfg.repeat_delay    <= cfg_data[15:0];
        kea_pkg::REG_REPEAT_INTERVAL: cfg.repeat_interval <= cfg_data[15:0];
        kea_pkg::REG_EMULATE_BUTTONS: cfg.emulate_buttons <= cfg_data[0];
        kea_pkg::REG_BUTTON2_KEY:     cfg.button2_key     <= cfg_data[6:0];
        kea_pkg::REG_BUTTON3_KEY:     cfg.button3_key     <= cfg_data[6:0];
        kea_pkg::REG_MOUSE_ATTACHED:  cfg.mouse_attached  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The three possible key paths are worked out side by side.
  always_comb begin
    tick_st              = st;
    tick_st.repeat_armed = 1'b0;
    ka = key_step(cfg, st, in_item.first_key_byte, 1'b0);
    kb = key_step(cfg, ka.st, in_item.second_key_byte, 1'b0);
    kt = key_step(cfg, tick_st, {1'b0, st.repeat_key}, 1'b1);
    second_present = !(in_item.second_key_byte == BYTE_ABSENT ||
                       (in_item.second_key_byte == BYTE_IDLE &&
                        in_item.first_key_byte == BYTE_IDLE));
    packet_ok = in_item.packet_length == kea_pkg::PKT_LEN && in_item.register_bits == 2'd0;
  end

  // Selection of the new state and of the result bundle.
  always_comb begin
    st_next = st;
    bundle  = '0;
    if (in_item.operation == kea_pkg::OP_TICK) begin
      if (st.repeat_armed) begin
        if (st.repeat_countdown > 16'd1) begin
          st_next.repeat_countdown = st.repeat_countdown - 16'd1;
        end else begin
          st_next         = kt.st;
          bundle.count    = kea_pkg::RES_CNT_W'(kt.n);
          bundle.res[1:0] = kt.res;
        end
      end
    end else if (packet_ok) begin
      if (second_present) begin
        st_next      = kb.st;
        bundle.count = kea_pkg::RES_CNT_W'(ka.n) + kea_pkg::RES_CNT_W'(kb.n);
        case (ka.n)
          2'd0: bundle.res[1:0] = kb.res;
          2'd1: begin
            bundle.res[0]   = ka.res[0];
            bundle.res[2:1] = kb.res;
          end
          default: begin
            bundle.res[1:0] = ka.res;
            bundle.res[3:2] = kb.res;
          end
        endcase
      end else begin
        st_next         = ka.st;
        bundle.count    = kea_pkg::RES_CNT_W'(ka.n);
        bundle.res[1:0] = ka.res;
      end
    end
  end

  assign bundle_push = accept && bundle.count != '0;

  // Repeat and button state advances on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.repeat_armed     <= 1'b0;
      st.repeat_countdown <= 16'd0;
      st.repeat_key       <= 7'd0;
      st.button2_up       <= 1'b1;
      st.button3_up       <= 1'b1;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

/* hw/rtl/kea_queue.sv */
// Short queue of result bundles between the front and the result side.
module kea_queue #(
  parameter int DEPTH = kea_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kea_pkg::bundle_t  push_bundle,
  output logic              full,
  input  logic              head_pop,
  output logic              head_valid,
  output kea_pkg::bundle_t  head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  kea_pkg::bundle_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_pop;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_pop     = head_pop && head_valid;

  // Bundle storage; written only on a push.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_bundle;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/kea_back.sv */
// Back part: hands out the results of the oldest bundle one item at a time.
module kea_back (
  input  logic                clk,
  input  logic                rst,
  input  kea_pkg::bundle_t    head,
  input  logic                head_valid,
  output logic                head_pop,
  output logic                empty,
  input  logic                pop,
  output kea_pkg::out_item_t  out_item
);

  logic [kea_pkg::RES_IDX_W-1:0] idx;
  logic                          is_last;
  logic                          take;
  kea_pkg::head_ctl_t            ctl;

  assign ctl.valid = head_valid;
  assign ctl.pop   = take && is_last;
  assign head_pop  = ctl.pop;

  assign empty   = !ctl.valid;
  assign take    = pop && ctl.valid;
  assign is_last = (kea_pkg::RES_CNT_W'(idx) + kea_pkg::RES_CNT_W'(1)) == head.count;

  // Current result of the head bundle, marked when it is the last one.
  always_comb begin
    out_item             = head.res[idx];
    out_item.last_result = is_last;
  end

  // Position within the head bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= is_last ? '0 : idx + 1'b1;
    end
  end

endmodule

/* hw/rtl/keyboard_event_autorepeat.sv */
// Top level of the keyboard autorepeat and mouse-button emulation block.
// One input item (a keyboard packet or a timer tick) is taken in every clock cycle while
// full is low; its translation, state update and classification take that same cycle, and
// its results (up to four) go as one bundle into a queue of QUEUE_DEPTH bundles. Results
// leave at one per cycle while pop is high, from the head of that queue; an item holds the
// result side until its last result is taken. The input side stalls only when the queue is
// full; items that cause no result take no queue space. There is no clearing pass after reset;
// configuration is written through a plain write port and takes effect on the next item.
module keyboard_event_autorepeat #(
  parameter int QUEUE_DEPTH = kea_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [kea_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kea_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  kea_pkg::in_item_t               in_item,
  output logic                            empty,
  input  logic                            pop,
  output kea_pkg::out_item_t              out_item
);

  logic             accept;
  logic             bundle_push;
  kea_pkg::bundle_t bundle;
  kea_pkg::bundle_t head;
  logic             head_valid;
  logic             head_pop;

  assign accept = push && !full;

  // Translation and state.
  kea_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .in_item     (in_item),
    .bundle_push (bundle_push),
    .bundle      (bundle)
  );

  // Bundles waiting for the result side.
  kea_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (bundle_push),
    .push_bundle (bundle),
    .full        (full),
    .head_pop    (head_pop),
    .head_valid  (head_valid),
    .head        (head)
  );

  // Result serialiser.
  kea_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule

/* hw/rtl/kea_checker.sv */
// Port-level checks on the keyboard autorepeat block, bound to its top level.
module kea_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input kea_pkg::in_item_t  in_item,
  input logic               empty,
  input logic               pop,
  input kea_pkg::out_item_t out_item
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // Nothing appears without an accepted packet or tick that can cause results.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    empty && (!(push && !full) ||
              (in_item.operation == kea_pkg::OP_PACKET &&
               in_item.packet_length != kea_pkg::PKT_LEN)) |=> empty)
    else $error("result appeared without a cause");

  // A result not marked last is always followed by another of the same item.
  a_bundle_continues: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !out_item.last_result |=> !empty)
    else $error("results of an item ended without a last mark");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed before it was taken");

endmodule

bind keyboard_event_autorepeat kea_checker u_kea_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .in_item  (in_item),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
